@@ design/rfg_pkg.sv @@
`timescale 1ns / 1ps

package rfg_pkg;

	// Receive buffer capacity in bytes
	localparam int RX_CAPACITY = 256;

	// Byte counter wide enough for the capacity, never below the 9-bit length field
	localparam int CNT_MIN_W = $clog2(RX_CAPACITY + 1);
	localparam int CNT_W = (CNT_MIN_W > 9) ? CNT_MIN_W : 9;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Item kinds on the input side
	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_BYTE    = 2'd1,
		CMD_TX_START = 2'd2,
		CMD_TX_DONE = 2'd3
	} cmd_t;

	// Result event codes
	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_ACCEPT     = 3'd1,
		EV_ADDR_MISS  = 3'd2,
		EV_CRC_ERR    = 3'd3,
		EV_IDLE       = 3'd4,
		EV_TX_END     = 3'd5
	} event_t;

	// Link state
	typedef enum logic [1:0] {
		LS_INIT = 2'd0,
		LS_IDLE = 2'd1,
		LS_TX   = 2'd2
	} link_t;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_SLAVE_ADDR = 2'd0,
		REG_SLAVE_MODE = 2'd1,
		REG_GAP_MS     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] slave_address;
		logic       slave_mode;
		logic [7:0] gap_ms;
	} cfg_t;

	// Modbus CRC-16, one byte per call, reflected polynomial
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

@@ design/rfg_cfg.sv @@
`timescale 1ns / 1ps

module rfg_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output rfg_pkg::cfg_t       cfg
);

	rfg_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Register file; writes to an unused index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address <= 8'd1;
			cfg_q.slave_mode    <= 1'b1;
			cfg_q.gap_ms        <= 8'd2;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rfg_pkg::REG_SLAVE_ADDR: cfg_q.slave_address <= cfg_data;
				rfg_pkg::REG_SLAVE_MODE: cfg_q.slave_mode    <= cfg_data[0];
				rfg_pkg::REG_GAP_MS:     cfg_q.gap_ms        <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ design/rfg_in_reg.sv @@
`timescale 1ns / 1ps

module rfg_in_reg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        take,
	output logic        valid_s1,
	output logic [1:0]  cmd_s1,
	output logic [7:0]  byte_s1
);

	// Input stage may refill in the cycle its item moves on
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

endmodule

@@ design/rfg_core.sv @@
`timescale 1ns / 1ps

module rfg_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rfg_pkg::cfg_t           cfg,
	input  logic                    valid_s1,
	input  logic [1:0]              cmd_s1,
	input  logic [7:0]              byte_s1,
	output logic                    take,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [2:0]              event_res,
	output logic [8:0]              frame_length,
	output logic [15:0]             request_id,
	output logic [1:0]              wire_state,
	output logic                    request_busy
);

	// Frame state
	rfg_pkg::link_t                 link_q, link_d;
	logic [rfg_pkg::CNT_W-1:0]      cnt_q, cnt_d;
	logic [7:0]                     sil_q, sil_d;
	logic [7:0]                     first_q, first_d;
	logic [15:0]                    crc_q, crc_d;
	logic                           busy_q, busy_d;
	logic [15:0]                    req_q, req_d;
	rfg_pkg::event_t                ev_d;
	logic [7:0]                     sil_inc;
	logic                           clr;

	// Result register
	logic                           res_valid_s2;
	rfg_pkg::event_t                ev_s2;

	assign take = valid_s1 && (!res_valid_s2 || m_tready);
	assign sil_inc = (sil_q == 8'hFF) ? sil_q : sil_q + 8'd1;

	// Next state for the item in the input register
	always_comb begin
		link_d  = link_q;
		cnt_d   = cnt_q;
		sil_d   = sil_q;
		first_d = first_q;
		crc_d   = crc_q;
		busy_d  = busy_q;
		req_d   = req_q;
		ev_d    = rfg_pkg::EV_NONE;
		clr     = 1'b0;
		unique case (rfg_pkg::cmd_t'(cmd_s1))
			rfg_pkg::CMD_TICK: begin
				if (link_q == rfg_pkg::LS_INIT) begin
					sil_d = sil_inc;
					if (sil_inc >= cfg.gap_ms) begin
						link_d = rfg_pkg::LS_IDLE;
						sil_d  = 8'd0;
						ev_d   = rfg_pkg::EV_IDLE;
					end
				end else if (link_q == rfg_pkg::LS_IDLE && !busy_q &&
						cnt_q != '0) begin
					sil_d = sil_inc;
					if (sil_inc >= cfg.gap_ms && cfg.slave_mode) begin
						if (first_q != cfg.slave_address) begin
							clr  = 1'b1;
							ev_d = rfg_pkg::EV_ADDR_MISS;
						end else if (cnt_q < rfg_pkg::CNT_W'(3) || crc_q != 16'd0) begin
							clr  = 1'b1;
							ev_d = rfg_pkg::EV_CRC_ERR;
						end else begin
							busy_d = 1'b1;
							req_d  = req_q + 16'd1;
							ev_d   = rfg_pkg::EV_ACCEPT;
						end
					end
				end
			end
			rfg_pkg::CMD_BYTE: begin
				if (link_q == rfg_pkg::LS_IDLE && !busy_q &&
						cnt_q < rfg_pkg::CNT_W'(rfg_pkg::RX_CAPACITY)) begin
					if (cnt_q == '0)
						first_d = byte_s1;
					cnt_d = cnt_q + rfg_pkg::CNT_W'(1);
					crc_d = rfg_pkg::crc_byte(crc_q, byte_s1);
					sil_d = 8'd0;
				end
			end
			rfg_pkg::CMD_TX_START: begin
				link_d = rfg_pkg::LS_TX;
			end
			rfg_pkg::CMD_TX_DONE: begin
				if (link_q == rfg_pkg::LS_TX) begin
					link_d = rfg_pkg::LS_IDLE;
					clr    = cfg.slave_mode;
					ev_d   = rfg_pkg::EV_TX_END;
				end
			end
			default: ;
		endcase
		// Drop the frame and start a new request
		if (clr) begin
			req_d  = req_q + 16'd1;
			busy_d = 1'b0;
			cnt_d  = '0;
			sil_d  = 8'd0;
			crc_d  = rfg_pkg::CRC_INIT;
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q  <= rfg_pkg::LS_INIT;
			cnt_q   <= '0;
			sil_q   <= 8'd0;
			first_q <= 8'd0;
			crc_q   <= rfg_pkg::CRC_INIT;
			busy_q  <= 1'b0;
			req_q   <= 16'd0;
		end else if (take) begin
			link_q  <= link_d;
			cnt_q   <= cnt_d;
			sil_q   <= sil_d;
			first_q <= first_d;
			crc_q   <= crc_d;
			busy_q  <= busy_d;
			req_q   <= req_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_s2 <= 1'b0;
		else if (!res_valid_s2 || m_tready)
			res_valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ev_s2        <= ev_d;
			frame_length <= cnt_d[8:0];
			request_id   <= req_d;
			wire_state   <= link_d;
			request_busy <= busy_d;
		end
	end

	assign m_tvalid  = res_valid_s2;
	assign event_res = ev_s2;

`ifndef ASSERT_OFF
	// A request can only be pending after init wait has ended
	a_busy_not_init: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> link_q != rfg_pkg::LS_INIT)
		else $error("busy request during init wait");

	// Byte count never passes capacity
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rfg_pkg::CNT_W'(rfg_pkg::RX_CAPACITY))
		else $error("byte count beyond capacity");

	// No bytes are collected before the link is idle the first time
	a_init_empty: assert property (@(posedge clk) disable iff (!arst_n)
		link_q == rfg_pkg::LS_INIT |-> cnt_q == '0)
		else $error("bytes counted during init wait");

	// An accepted frame is reported with its request marked busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ev_s2 == rfg_pkg::EV_ACCEPT) |-> request_busy)
		else $error("accepted frame without busy request");

	// Result register only loads when an item moves out of the input stage
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid && !valid_s1) |=> !m_tvalid)
		else $error("result appeared without an item");
`endif

endmodule

@@ design/rtu_frame_gap_receiver.sv @@
`timescale 1ns / 1ps

// Modbus RTU receive-side frame tracker. Each input item is a millisecond tick,
// a received byte, a transmit start or a transmit done, and each one yields
// exactly one result item carrying an event code, the current byte count, the
// request id, the link state and the busy flag. After reset the link waits
// gap_ms ticks, then goes idle; idle bytes are counted and run through the
// Modbus CRC-16; in slave mode gap_ms ticks of silence end the frame, which is
// checked against slave_address and the CRC. One item is taken every clock
// cycle while the result side keeps up. Each item passes the input register
// and then the result register, with the whole CRC byte update done
// combinationally between them. While m_tready is low the result register
// and the input register each hold one item, and s_tready drops until the
// result is taken. Configuration writes are taken at any time but should
// only be made while no items are in flight.
module rtu_frame_gap_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// Input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	// Result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [8:0] frame_length, [24:9] request_id,
	                               // [26:25] wire_state, [27] request_busy, rest zero
	output logic [2:0]  m_tuser,   // [2:0] event_res
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	rfg_pkg::cfg_t cfg;
	logic          take;
	logic          valid_s1;
	logic [1:0]    cmd_s1;
	logic [7:0]    byte_s1;
	logic [8:0]    frame_length;
	logic [15:0]   request_id;
	logic [1:0]    wire_state;
	logic          request_busy;

	rfg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rfg_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.take     (take),
		.valid_s1 (valid_s1),
		.cmd_s1   (cmd_s1),
		.byte_s1  (byte_s1)
	);

	rfg_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.valid_s1     (valid_s1),
		.cmd_s1       (cmd_s1),
		.byte_s1      (byte_s1),
		.take         (take),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.event_res    (m_tuser),
		.frame_length (frame_length),
		.request_id   (request_id),
		.wire_state   (wire_state),
		.request_busy (request_busy)
	);

	assign m_tdata = {4'd0, request_busy, wire_state, request_id, frame_length};

endmodule
